@@ rtl/core/dtr_pkg.sv @@
// dtr_pkg: shared types, codes and defaults of the dirty tile rectangle tracker
// no dependencies; imported by every module of the block
`default_nettype none

package dtr_pkg;

  // grid shape defaults
  localparam int DEF_GRID_COLS  = 8;
  localparam int DEF_GRID_ROWS  = 8;
  localparam int DEF_TILE_SHIFT = 6;

  // a drain stops after this many rectangles
  localparam int MAX_RESULTS = 32;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_ENABLE = 2'd2;

  localparam logic [9:0] RST_IMAGE_WIDTH  = 10'd512;
  localparam logic [9:0] RST_IMAGE_HEIGHT = 10'd512;

  // command codes
  localparam logic [1:0] FUNC_MARK  = 2'd0;
  localparam logic [1:0] FUNC_FULL  = 2'd1;
  localparam logic [1:0] FUNC_DRAIN = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [8:0] region_x;
    logic [8:0] region_y;
    logic [9:0] region_w;
    logic [9:0] region_h;
    logic       upload_ready;
  } cmd_t;

  typedef struct packed {
    logic [8:0] rect_x;
    logic [8:0] rect_y;
    logic [9:0] rect_w;
    logic [9:0] rect_h;
    logic       last;
  } rect_t;

  typedef struct packed {
    logic [9:0] image_width;
    logic [9:0] image_height;
    logic       track_enable;
  } cfg_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear_all;
  } mem_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/dtr_row_mem.sv @@
// dtr_row_mem: dirty grid storage, one grid row per entry, registered read
// depends on dtr_pkg for the control struct
`default_nettype none

module dtr_row_mem import dtr_pkg::*; #(
  parameter int ROWS = DEF_GRID_ROWS,
  parameter int COLS = DEF_GRID_COLS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire mem_ctl_t                               ctl,
  input  wire logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rd_addr,
  input  wire logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] wr_addr,
  input  wire logic [COLS-1:0]                        wr_data,
  output logic      [COLS-1:0]                        rd_data
);

  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_valid;
  logic [COLS-1:0] rd_q;
  logic            rd_vq;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // a row never written since reset or the last clear reads as all clean
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_vq     <= 1'b0;
    end else begin
      if (ctl.clear_all) begin
        row_valid <= '0;
      end else if (ctl.wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vq <= row_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_vq ? rd_q : '0;

endmodule

`default_nettype wire

@@ rtl/core/dtr_ctrl.sv @@
// dtr_ctrl: command sequencer, row read-modify-write, greedy rectangle scan
// and result register; depends on dtr_pkg and drives dtr_row_mem
`default_nettype none

module dtr_ctrl import dtr_pkg::*; #(
  parameter int GRID_COLS  = DEF_GRID_COLS,
  parameter int GRID_ROWS  = DEF_GRID_ROWS,
  parameter int TILE_SHIFT = DEF_TILE_SHIFT
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire logic                                         cmd_valid,
  output logic                                              cmd_stall,
  input  wire cmd_t                                         cmd,
  input  wire cfg_t                                         cfg,
  input  wire logic [$clog2(GRID_COLS+1)-1:0]               grid_w,
  input  wire logic [$clog2(GRID_ROWS+1)-1:0]               grid_h,
  output mem_ctl_t                                          mem_ctl,
  output logic [((GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1)-1:0] mem_rd_addr,
  output logic [((GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1)-1:0] mem_wr_addr,
  output logic [GRID_COLS-1:0]                              mem_wr_data,
  input  wire logic [GRID_COLS-1:0]                         mem_rd_data,
  output logic                                              rect_valid,
  input  wire logic                                         rect_stall,
  output rect_t                                             rect
);

  localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int CNT_W  = $clog2(GRID_COLS + 1);
  localparam int RCNT_W = $clog2(GRID_ROWS + 1);
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);
  localparam int PX_W   = (CNT_W + TILE_SHIFT > 10) ? CNT_W + TILE_SHIFT : 10;
  localparam int PY_W   = (RCNT_W + TILE_SHIFT > 10) ? RCNT_W + TILE_SHIFT : 10;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MRD   = 4'd1;
  localparam logic [3:0] S_MWR   = 4'd2;
  localparam logic [3:0] S_DRD   = 4'd3;
  localparam logic [3:0] S_DLOAD = 4'd4;
  localparam logic [3:0] S_DFIND = 4'd5;
  localparam logic [3:0] S_DRUN  = 4'd6;
  localparam logic [3:0] S_DDRD  = 4'd7;
  localparam logic [3:0] S_DDCHK = 4'd8;
  localparam logic [3:0] S_DPUSH = 4'd9;
  localparam logic [3:0] S_DWB   = 4'd10;
  localparam logic [3:0] S_DEND  = 4'd11;

  logic [3:0]           state;
  logic                 full_flag;
  logic [ROW_W-1:0]     mark_row;
  logic [ROW_W-1:0]     mark_end;
  logic [GRID_COLS-1:0] mark_mask;
  logic [ROW_W-1:0]     gy;
  logic [COL_W-1:0]     gx;
  logic [CNT_W-1:0]     col;
  logic [CNT_W-1:0]     ex;
  logic [RCNT_W-1:0]    ey;
  logic [GRID_COLS-1:0] cur_row;
  logic [GRID_COLS-1:0] run_mask;
  logic [RES_W-1:0]     count;
  rect_t                pend;
  logic                 pend_valid;

  // mark decode
  logic [10:0]          x_end;
  logic [10:0]          y_end;
  logic [10:0]          tx0;
  logic [10:0]          ty0;
  logic [10:0]          tx1;
  logic [10:0]          ty1;
  logic [10:0]          gw_m1;
  logic [10:0]          gh_m1;
  logic [GRID_COLS-1:0] mark_calc;
  logic                 mark_ok;

  always_comb begin
    x_end = 11'(cmd.region_x) + 11'(cmd.region_w) - 11'd1;
    y_end = 11'(cmd.region_y) + 11'(cmd.region_h) - 11'd1;
    tx0   = 11'(cmd.region_x) >> TILE_SHIFT;
    ty0   = 11'(cmd.region_y) >> TILE_SHIFT;
    gw_m1 = 11'(grid_w) - 11'd1;
    gh_m1 = 11'(grid_h) - 11'd1;
    tx1   = x_end >> TILE_SHIFT;
    ty1   = y_end >> TILE_SHIFT;
    if (tx1 > gw_m1) begin
      tx1 = gw_m1;
    end
    if (ty1 > gh_m1) begin
      ty1 = gh_m1;
    end
    for (int i = 0; i < GRID_COLS; i++) begin
      mark_calc[i] = (11'(i) >= tx0) && (11'(i) <= tx1);
    end
    mark_ok = cfg.track_enable && cmd.upload_ready && !full_flag &&
              (cmd.region_w != '0) && (cmd.region_h != '0) &&
              (grid_w != '0) && (grid_h != '0) && (tx0 <= tx1) && (ty0 <= ty1);
  end

  // first dirty tile at or after col, and the end of its run
  logic                 found;
  logic [COL_W-1:0]     first;
  logic [CNT_W-1:0]     ex_calc;
  logic [GRID_COLS-1:0] run_calc;

  always_comb begin
    found = 1'b0;
    first = '0;
    for (int i = GRID_COLS - 1; i >= 0; i--) begin
      if (cur_row[i] && (CNT_W'(i) >= col) && (CNT_W'(i) < grid_w)) begin
        found = 1'b1;
        first = COL_W'(i);
      end
    end
  end

  always_comb begin
    ex_calc = grid_w;
    for (int i = GRID_COLS - 1; i >= 0; i--) begin
      if ((CNT_W'(i) > CNT_W'(gx)) && (!cur_row[i] || (CNT_W'(i) >= grid_w))) begin
        ex_calc = CNT_W'(i);
      end
    end
    for (int i = 0; i < GRID_COLS; i++) begin
      run_calc[i] = (CNT_W'(i) >= CNT_W'(gx)) && (CNT_W'(i) < ex_calc);
    end
  end

  // pixel rectangle of the region just grown
  logic [PX_W-1:0] px;
  logic [PX_W-1:0] xe;
  logic [PY_W-1:0] py;
  logic [PY_W-1:0] ye;
  logic [PX_W-1:0] rw_calc;
  logic [PY_W-1:0] rh_calc;
  rect_t           new_rect;

  always_comb begin
    px = PX_W'(gx) << TILE_SHIFT;
    xe = PX_W'(ex) << TILE_SHIFT;
    py = PY_W'(gy) << TILE_SHIFT;
    ye = PY_W'(ey) << TILE_SHIFT;
    if (xe > PX_W'(cfg.image_width)) begin
      xe = PX_W'(cfg.image_width);
    end
    if (ye > PY_W'(cfg.image_height)) begin
      ye = PY_W'(cfg.image_height);
    end
    rw_calc         = xe - px;
    rh_calc         = ye - py;
    new_rect.rect_x = px[8:0];
    new_rect.rect_y = py[8:0];
    new_rect.rect_w = rw_calc[9:0];
    new_rect.rect_h = rh_calc[9:0];
    new_rect.last   = 1'b0;
  end

  logic            rect_free;
  logic            push_go;
  logic            end_go;
  logic            rect_load;
  rect_t           rect_next;
  logic            down_hit;
  logic [RCNT_W-1:0] gy_inc;

  assign rect_free = !rect_valid || !rect_stall;
  assign push_go   = (state == S_DPUSH) && (!pend_valid || rect_free);
  assign end_go    = (state == S_DEND) && rect_free;
  assign rect_load = (push_go && pend_valid) || end_go;
  assign down_hit  = (mem_rd_data & run_mask) == run_mask;
  assign gy_inc    = RCNT_W'(gy) + 1'b1;
  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    rect_next = pend;
    if (end_go) begin
      if (pend_valid) begin
        rect_next.last = 1'b1;
      end else begin
        rect_next.rect_x = '0;
        rect_next.rect_y = '0;
        rect_next.rect_w = cfg.image_width;
        rect_next.rect_h = cfg.image_height;
        rect_next.last   = 1'b1;
      end
    end
  end

  // memory port control
  always_comb begin
    mem_ctl.rd_en     = (state == S_MRD) || (state == S_DRD) || (state == S_DDRD);
    mem_ctl.wr_en     = (state == S_MWR) || ((state == S_DFIND) && !found) ||
                        ((state == S_DDCHK) && down_hit) || (state == S_DWB);
    mem_ctl.clear_all = (state == S_IDLE) && cmd_valid && (cmd.func == FUNC_FULL);
    case (state)
      S_MRD:   mem_rd_addr = mark_row;
      S_DRD:   mem_rd_addr = gy;
      default: mem_rd_addr = ey[ROW_W-1:0];
    endcase
    case (state)
      S_MWR: begin
        mem_wr_addr = mark_row;
        mem_wr_data = mem_rd_data | mark_mask;
      end
      S_DDCHK: begin
        mem_wr_addr = ey[ROW_W-1:0];
        mem_wr_data = mem_rd_data & ~run_mask;
      end
      default: begin
        mem_wr_addr = gy;
        mem_wr_data = cur_row;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      full_flag  <= 1'b0;
      rect_valid <= 1'b0;
      pend_valid <= 1'b0;
      count      <= '0;
    end else begin
      if (rect_load) begin
        rect_valid <= 1'b1;
        rect       <= rect_next;
      end else if (rect_valid && !rect_stall) begin
        rect_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.func)
              FUNC_MARK: begin
                if (mark_ok) begin
                  mark_row  <= ty0[ROW_W-1:0];
                  mark_end  <= ty1[ROW_W-1:0];
                  mark_mask <= mark_calc;
                  state     <= S_MRD;
                end
              end
              FUNC_FULL: begin
                full_flag <= 1'b1;
              end
              FUNC_DRAIN: begin
                pend_valid <= 1'b0;
                count      <= '0;
                gy         <= '0;
                if (!full_flag && cfg.track_enable && (grid_w != '0) && (grid_h != '0)) begin
                  state <= S_DRD;
                end else begin
                  state <= S_DEND;
                end
              end
              FUNC_CLEAR: begin
                full_flag <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_MRD: begin
          state <= S_MWR;
        end
        S_MWR: begin
          if (mark_row == mark_end) begin
            state <= S_IDLE;
          end else begin
            mark_row <= mark_row + 1'b1;
            state    <= S_MRD;
          end
        end
        S_DRD: begin
          state <= S_DLOAD;
        end
        S_DLOAD: begin
          cur_row <= mem_rd_data;
          col     <= '0;
          state   <= S_DFIND;
        end
        S_DFIND: begin
          if (found) begin
            gx    <= first;
            state <= S_DRUN;
          end else if (gy_inc == grid_h) begin
            state <= S_DEND;
          end else begin
            gy    <= gy + 1'b1;
            state <= S_DRD;
          end
        end
        S_DRUN: begin
          ex       <= ex_calc;
          run_mask <= run_calc;
          cur_row  <= cur_row & ~run_calc;
          ey       <= gy_inc;
          state    <= (gy_inc < grid_h) ? S_DDRD : S_DPUSH;
        end
        S_DDRD: begin
          state <= S_DDCHK;
        end
        S_DDCHK: begin
          if (down_hit) begin
            ey    <= ey + 1'b1;
            state <= ((ey + 1'b1) < grid_h) ? S_DDRD : S_DPUSH;
          end else begin
            state <= S_DPUSH;
          end
        end
        S_DPUSH: begin
          if (push_go) begin
            pend       <= new_rect;
            pend_valid <= 1'b1;
            count      <= count + 1'b1;
            col        <= ex;
            state      <= ((count + 1'b1) == RES_W'(MAX_RESULTS)) ? S_DWB : S_DFIND;
          end
        end
        S_DWB: begin
          state <= S_DEND;
        end
        S_DEND: begin
          if (rect_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_result_cap: assert property (@(posedge clk) disable iff (rst)
    count <= RES_W'(MAX_RESULTS))
    else $error("drain produced more rectangles than the cap");

  a_no_same_row_rw: assert property (@(posedge clk) disable iff (rst)
    !(mem_ctl.rd_en && mem_ctl.wr_en && (mem_rd_addr == mem_wr_addr)))
    else $error("row read and written in the same cycle");

  a_last_ends_drain: assert property (@(posedge clk) disable iff (rst)
    end_go |=> (state == S_IDLE))
    else $error("drain did not finish after its last rectangle");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    push_go |=> (count == $past(count) + 1'b1) && pend_valid)
    else $error("grown rectangle not counted");

endmodule

`default_nettype wire

@@ rtl/core/dirty_tile_rect_tracker_top.sv @@
// dirty_tile_rect_tracker_top: configuration registers, grid span and the
// scan controller with its row memory; depends on dtr_pkg, dtr_ctrl, dtr_row_mem
`default_nettype none

// one command at a time; cmd_stall is high after the transfer until a mark or drain is done
// mark: accepted, then a row read and a write back for each tile row it covers
// drain: a read, load and search for each grid row scanned, plus a run, push and search per
//   rectangle and a read and check per row tested below it, then the final rectangle's hand-off
// full set / full clear: taken without a stall; a result sits in an output register until transferred
// synchronous reset clears the grid at once through per-row valid bits (no clearing pass)
module dirty_tile_rect_tracker_top import dtr_pkg::*; #(
  parameter int GRID_COLS  = DEF_GRID_COLS,
  parameter int GRID_ROWS  = DEF_GRID_ROWS,
  parameter int TILE_SHIFT = DEF_TILE_SHIFT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // command channel
  input  wire logic                  cmd_valid,
  output logic                       cmd_stall,
  input  wire cmd_t                  cmd,
  // rectangle channel
  output logic                       rect_valid,
  input  wire logic                  rect_stall,
  output rect_t                      rect,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int CNT_W  = $clog2(GRID_COLS + 1);
  localparam int RCNT_W = $clog2(GRID_ROWS + 1);
  // rounding term for the tile count, tile size minus one
  localparam logic [10:0] TILE_M1 = 11'((1 << TILE_SHIFT) - 1);

  cfg_t cfg;

  // image size and tracking enable: user writes only with no command in flight, unchecked
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= RST_IMAGE_WIDTH;
      cfg.image_height <= RST_IMAGE_HEIGHT;
      cfg.track_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data;
        REG_TRACK_ENABLE: cfg.track_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // grid in use: tiles that the image touches, capped at the stored grid
  logic [10:0]       span_x;
  logic [10:0]       span_y;
  logic [CNT_W-1:0]  grid_w;
  logic [RCNT_W-1:0] grid_h;

  always_comb begin
    span_x = (11'(cfg.image_width) + TILE_M1) >> TILE_SHIFT;
    span_y = (11'(cfg.image_height) + TILE_M1) >> TILE_SHIFT;
    grid_w = (span_x > 11'(GRID_COLS)) ? CNT_W'(GRID_COLS) : span_x[CNT_W-1:0];
    grid_h = (span_y > 11'(GRID_ROWS)) ? RCNT_W'(GRID_ROWS) : span_y[RCNT_W-1:0];
  end

  // controller to memory
  mem_ctl_t             mem_ctl;
  logic [ROW_W-1:0]     mem_rd_addr;
  logic [ROW_W-1:0]     mem_wr_addr;
  logic [GRID_COLS-1:0] mem_wr_data;
  logic [GRID_COLS-1:0] mem_rd_data;

  // one grid row per entry, dirty bit of tile gx at bit gx
  dtr_row_mem #(
    .ROWS (GRID_ROWS),
    .COLS (GRID_COLS)
  ) u_row_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .rd_addr (mem_rd_addr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

  // command sequencing, raster scan with right-then-down growth, result register
  dtr_ctrl #(
    .GRID_COLS  (GRID_COLS),
    .GRID_ROWS  (GRID_ROWS),
    .TILE_SHIFT (TILE_SHIFT)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .cfg         (cfg),
    .grid_w      (grid_w),
    .grid_h      (grid_h),
    .mem_ctl     (mem_ctl),
    .mem_rd_addr (mem_rd_addr),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_data (mem_rd_data),
    .rect_valid  (rect_valid),
    .rect_stall  (rect_stall),
    .rect        (rect)
  );

endmodule

`default_nettype wire
